### hdl/raised_cosine_ramp_core_assert.svh
// Assertion macros for the raised-cosine ramp core.
// Depends on nothing; included by the top level.
`ifndef RAISED_COSINE_RAMP_CORE_ASSERT_SVH
`define RAISED_COSINE_RAMP_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// fixed-delay implication, disabled in reset
`define RCR_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

### hdl/rcr_pkg.sv
// Shared constants and the CORDIC arctangent table for the raised-cosine ramp.
// Depends on nothing.
`default_nettype none
package rcr_pkg;
   localparam int ANG_BITS  = 31;            // binary angle, pi = 2^31
   localparam int XY_BITS   = 33;            // CORDIC x/y, Q30 with headroom
   localparam int Z_BITS    = 32;            // CORDIC residual angle
   localparam int TABLE_LEN = 30;
   localparam logic signed [XY_BITS-1:0] GAIN_Q30 = 33'sd652032874;
   localparam logic signed [XY_BITS-1:0] ONE_Q30  = 33'sd1073741824;
   localparam logic [ANG_BITS:0] ANG_PI      = 32'h8000_0000;
   localparam logic [ANG_BITS:0] ANG_HALF_PI = 32'h4000_0000;

   // arctangent of 2^-i, pi = 2^30 scale
   function automatic logic signed [Z_BITS-1:0] atan_half(input int idx);
      logic [31:0] t;
      case (idx)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
         15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
         18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
         21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
         24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
         27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      return $signed(t >> 1);
   endfunction
endpackage
`default_nettype wire

### hdl/rcr_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle.
// Depends on rcr_pkg.
`default_nettype none
module rcr_div_cell #(
   parameter int DW = 32
) (
   input  wire logic                        clock,
   input  wire logic [DW-1:0]               rem_i,
   input  wire logic [DW-1:0]               den_i,
   input  wire logic [rcr_pkg::ANG_BITS-1:0] quo_i,
   output logic      [DW-1:0]               rem_o,
   output logic      [DW-1:0]               den_o,
   output logic      [rcr_pkg::ANG_BITS-1:0] quo_o
);
   logic [DW:0]   rem2;
   logic          take;
   logic [DW:0]   rem_in;

   // shift remainder, trial subtract
   assign rem2   = {rem_i, 1'b0};
   assign take   = (rem2 >= {1'b0, den_i});
   assign rem_in = take ? (rem2 - {1'b0, den_i}) : rem2;

   // hand on to the next cell
   always_ff @(posedge clock) begin
      rem_o <= rem_in[DW-1:0];
      den_o <= den_i;
      quo_o <= {quo_i[rcr_pkg::ANG_BITS-2:0], take};
   end
endmodule
`default_nettype wire

### hdl/rcr_cordic_cell.sv
// One CORDIC rotation-mode cell with a fixed shift.
// Depends on rcr_pkg.
`default_nettype none
module rcr_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                              clock,
   input  wire logic signed [rcr_pkg::XY_BITS-1:0] x_i,
   input  wire logic signed [rcr_pkg::XY_BITS-1:0] y_i,
   input  wire logic signed [rcr_pkg::Z_BITS-1:0]  z_i,
   input  wire logic                              flip_i,
   output logic signed      [rcr_pkg::XY_BITS-1:0] x_o,
   output logic signed      [rcr_pkg::XY_BITS-1:0] y_o,
   output logic signed      [rcr_pkg::Z_BITS-1:0]  z_o,
   output logic                                   flip_o
);
   localparam logic signed [rcr_pkg::Z_BITS-1:0] ATAN = rcr_pkg::atan_half(STAGE);
   logic signed [rcr_pkg::XY_BITS-1:0] dx;
   logic signed [rcr_pkg::XY_BITS-1:0] dy;

   assign dx = y_i >>> STAGE;
   assign dy = x_i >>> STAGE;

   // rotate toward zero residual angle
   always_ff @(posedge clock) begin
      if (z_i >= 0) begin
         x_o <= x_i - dx;
         y_o <= y_i + dy;
         z_o <= z_i - ATAN;
      end else begin
         x_o <= x_i + dx;
         y_o <= y_i - dy;
         z_o <= z_i + ATAN;
      end
      flip_o <= flip_i;
   end
endmodule
`default_nettype wire

### hdl/raised_cosine_ramp_core.sv
// Raised-cosine ramp core: divider cells, CORDIC cells and blend, fully pipelined.
// Depends on rcr_pkg, rcr_div_cell, rcr_cordic_cell, raised_cosine_ramp_core_assert.svh.
//
// Takes one request per clock (busy stays low) and returns each result on
// rsp_ramp_value with rsp_strobe high for one cycle. Each request passes through
// the 31-cell quotient chain (one angle bit per cell), the CORDIC_STAGES rotation
// cells and five registers for input, fold, weight, multiply and output.
// Results cannot be stalled; the receiver must take each one in the cycle it is shown.
`default_nettype none
`include "raised_cosine_ramp_core_assert.svh"
module raised_cosine_ramp_core #(
   parameter int DATA_WIDTH    = 32,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_mode,
   input  wire logic signed [DATA_WIDTH-1:0] req_sample,
   input  wire logic signed [DATA_WIDTH-1:0] req_edge_low,
   input  wire logic signed [DATA_WIDTH-1:0] req_edge_high,
   input  wire logic signed [DATA_WIDTH-1:0] req_level_low,
   input  wire logic signed [DATA_WIDTH-1:0] req_level_high,
   output logic                              rsp_strobe,
   output logic signed      [DATA_WIDTH-1:0] rsp_ramp_value
);
   localparam int DW     = DATA_WIDTH;
   localparam int AB     = rcr_pkg::ANG_BITS;
   localparam int XB     = rcr_pkg::XY_BITS;
   localparam int ZB     = rcr_pkg::Z_BITS;
   localparam int FOLD   = AB + 1;                 // stage of fold register
   localparam int POST   = FOLD + CORDIC_STAGES + 1;
   localparam int MULS   = POST + 1;
   localparam int LAST   = MULS;                   // last side-band stage
   localparam int LAT    = MULS + 2;
   localparam int PW     = DW + 1 + XB;

   typedef struct packed {
      logic          mode;
      logic          clamp;
      logic [DW-1:0] clampv;
      logic [DW-1:0] ylo;
      logic [DW:0]   dlev;
   } side_type;

   logic                   accept;
   logic                   valid_ff [0:LAST];
   side_type               side_ff  [0:LAST];
   logic [DW-1:0]          rem_w    [0:AB];
   logic [DW-1:0]          den_w    [0:AB];
   logic [AB-1:0]          quo_w    [0:AB];
   logic signed [XB-1:0]   cx_w     [0:CORDIC_STAGES];
   logic signed [XB-1:0]   cy_w     [0:CORDIC_STAGES];
   logic signed [ZB-1:0]   cz_w     [0:CORDIC_STAGES];
   logic                   cf_w     [0:CORDIC_STAGES];
   logic [DW-1:0]          rem0_ff, den0_ff;
   logic signed [ZB-1:0]   cz0_ff;
   logic                   cf0_ff;
   logic signed [DW:0]     x_ext, lo_ext, hi_ext, diff, width;
   logic                   at_low, at_high;
   logic [AB:0]            ang, ang_in;
   logic                   fold_neg;
   logic signed [XB-1:0]   cos_c, cos_s;
   logic [AB-1:0]          wt_in, wt_ff;
   logic signed [PW-1:0]   prod_in, prod_ff, prod_r;
   logic [DW-1:0]          out_in;
   logic                   strobe_ff;
   logic [DW-1:0]          value_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // classify the sample against the interval
   assign x_ext   = {req_sample[DW-1], req_sample};
   assign lo_ext  = {req_edge_low[DW-1], req_edge_low};
   assign hi_ext  = {req_edge_high[DW-1], req_edge_high};
   assign diff    = x_ext - lo_ext;
   assign width   = hi_ext - lo_ext;
   assign at_low  = (x_ext <= lo_ext);
   assign at_high = (x_ext >= hi_ext);

   // hold valid flags in a reset shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) valid_ff[k] <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff[0] <= accept;
         for (int k = 1; k <= LAST; k++) valid_ff[k] <= valid_ff[k-1];
         strobe_ff <= valid_ff[LAST];
      end
   end

   // capture request and advance side-band
   always_ff @(posedge clock) begin
      side_ff[0].mode   <= req_mode;
      side_ff[0].clamp  <= at_low || at_high;
      side_ff[0].clampv <= (at_low ^ req_mode) ? req_level_high : req_level_low;
      side_ff[0].ylo    <= req_level_low;
      side_ff[0].dlev   <= {req_level_high[DW-1], req_level_high}
                         - {req_level_low[DW-1], req_level_low};
      rem0_ff <= diff[DW-1:0];
      den0_ff <= width[DW-1:0];
      for (int k = 1; k <= LAST; k++) side_ff[k] <= side_ff[k-1];
   end

   // feed the head of the quotient chain
   assign rem_w[0] = rem0_ff;
   assign den_w[0] = den0_ff;
   assign quo_w[0] = '0;

   // quotient chain: one angle bit per cell
   for (genvar k = 0; k < AB; k++) begin : g_div
      rcr_div_cell #(.DW(DW)) u_div (
         .clock (clock),
         .rem_i (rem_w[k]),   .den_i (den_w[k]),   .quo_i (quo_w[k]),
         .rem_o (rem_w[k+1]), .den_o (den_w[k+1]), .quo_o (quo_w[k+1])
      );
   end

   // fold angle into first quadrant
   assign ang      = {1'b0, quo_w[AB]};
   assign fold_neg = (ang > rcr_pkg::ANG_HALF_PI);
   assign ang_in   = fold_neg ? (rcr_pkg::ANG_PI - ang) : ang;

   always_ff @(posedge clock) begin
      cz0_ff <= $signed(ZB'(ang_in >> 1));
      cf0_ff <= fold_neg ^ side_ff[AB].mode;
   end

   // feed the head of the rotation chain
   assign cx_w[0] = rcr_pkg::GAIN_Q30;
   assign cy_w[0] = '0;
   assign cz_w[0] = cz0_ff;
   assign cf_w[0] = cf0_ff;

   // rotation chain
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      rcr_cordic_cell #(.STAGE(i)) u_cordic (
         .clock  (clock),
         .x_i    (cx_w[i]),   .y_i (cy_w[i]),   .z_i (cz_w[i]),   .flip_i (cf_w[i]),
         .x_o    (cx_w[i+1]), .y_o (cy_w[i+1]), .z_o (cz_w[i+1]), .flip_o (cf_w[i+1])
      );
   end

   // clamp cosine, apply sign, form weight
   always_comb begin
      cos_c = cx_w[CORDIC_STAGES];
      if (cos_c > rcr_pkg::ONE_Q30) cos_c = rcr_pkg::ONE_Q30;
      if (cos_c < -rcr_pkg::ONE_Q30) cos_c = -rcr_pkg::ONE_Q30;
      cos_s = cf_w[CORDIC_STAGES] ? -cos_c : cos_c;
      wt_in = AB'((cos_s + rcr_pkg::ONE_Q30) >>> 1);
   end

   // multiply level span by weight
   assign prod_in = PW'($signed(side_ff[POST].dlev) * $signed({{(XB-AB){1'b0}}, wt_ff}));

   // round, scale and offset, or take the clamp level
   assign prod_r = (prod_ff + (PW'(1) <<< 29)) >>> 30;
   assign out_in = side_ff[LAST].clamp ? side_ff[LAST].clampv
                                       : side_ff[LAST].ylo + prod_r[DW-1:0];

   always_ff @(posedge clock) begin
      wt_ff    <= wt_in;
      prod_ff  <= prod_in;
      value_ff <= out_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ramp_value = value_ff;

   `RCR_ASSERT_DELAY(a_latency, clock, reset, accept, LAT, rsp_strobe, "result missing at fixed latency")
   `RCR_ASSERT_SAME(a_weight, clock, reset, valid_ff[POST], wt_ff <= AB'(1 << 30), "weight above one")
   `RCR_ASSERT_SAME(a_fold, clock, reset, valid_ff[FOLD] && !side_ff[FOLD].clamp, cz_w[0] <= ZB'(1 << 29), "folded angle beyond quarter turn")
endmodule
`default_nettype wire
